>>> design/psfr_pkg.sv
// Shared types and fixed field widths for the position synced frame ring.
// Used by the controller, the datapath and the top level; depends on nothing.
package psfr_pkg;

  // Fixed widths of the item and result fields.
  localparam int POS_W   = 64;
  localparam int FRAME_W = 32;
  localparam int COUNT_W = 7;
  localparam int CFG_W   = 11;
  localparam int CNT_W   = 10;

  // Function codes of an input item.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic calc;        // position difference and ring flags
    logic clamp;       // gap clamp, or restart of an empty ring
    logic push;        // store one frame at the tail
    logic push_zero;   // the pushed frame is a zero-filled one
    logic finish;      // advance positions and totals past the clamped gap
    logic emit_write;  // present the write result
    logic check;       // read range check and start slot
    logic issue;       // read one slot
    logic emit_err;    // present the read error result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic read_op;
    logic fill_zero;
    logic fill_one;
    logic rd_err;
    logic rd_last;
  } sts_t;

endpackage

>>> design/psfr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old contents. No dependencies.
module psfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read in one process.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/psfr_ctrl.sv
// Sequencing controller of the frame ring: one-hot state machine issuing commands.
// Depends on psfr_pkg for the command and status structs.
module psfr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  psfr_pkg::sts_t sts,
  output psfr_pkg::cmd_t cmd,
  output logic           busy
);
  import psfr_pkg::*;

  typedef enum logic [8:0] {
    IDLE     = 9'b000000001,
    CALC     = 9'b000000010,
    W_CLAMP  = 9'b000000100,
    W_FILL   = 9'b000001000,
    W_PUSH   = 9'b000010000,
    W_END    = 9'b000100000,
    W_RESULT = 9'b001000000,
    R_CHECK  = 9'b010000000,
    R_ISSUE  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = CALC;
        end
      end
      CALC: begin
        cmd.calc   = 1'b1;
        state_next = sts.read_op ? R_CHECK : W_CLAMP;
      end
      W_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = W_FILL;
      end
      W_FILL: begin
        // One zero frame per cycle until the clamped gap is used up.
        if (!sts.fill_zero) begin
          cmd.push      = 1'b1;
          cmd.push_zero = 1'b1;
        end
        if (sts.fill_zero || sts.fill_one) begin
          state_next = W_PUSH;
        end
      end
      W_PUSH: begin
        cmd.push   = 1'b1;
        state_next = W_END;
      end
      W_END: begin
        cmd.finish = 1'b1;
        state_next = W_RESULT;
      end
      W_RESULT: begin
        cmd.emit_write = 1'b1;
        state_next     = IDLE;
      end
      R_CHECK: begin
        cmd.check  = 1'b1;
        state_next = R_ISSUE;
      end
      R_ISSUE: begin
        if (sts.rd_err) begin
          cmd.emit_err = 1'b1;
          state_next   = IDLE;
        end else begin
          cmd.issue = 1'b1;
          if (sts.rd_last) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

>>> design/psfr_dp.sv
// Datapath of the frame ring: indices, positions, totals, frame memory, result registers.
// Depends on psfr_pkg and instantiates psfr_ram for frames and their zero-fill marks.
module psfr_dp #(
  parameter int MAX_SLOTS  = 1024,
  parameter int FRAME_BITS = 32,
  parameter int MAX_READ   = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  psfr_pkg::cmd_t                 cmd,
  output psfr_pkg::sts_t                 sts,
  input  logic                           cfg_we,
  input  logic [psfr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           func,
  input  logic [psfr_pkg::POS_W-1:0]     position,
  input  logic [psfr_pkg::FRAME_W-1:0]   frame_in,
  input  logic [psfr_pkg::COUNT_W-1:0]   count,
  output logic                           result_strobe,
  output logic [psfr_pkg::FRAME_W-1:0]   frame_out,
  output logic                           last,
  output logic                           status,
  output logic [psfr_pkg::CNT_W-1:0]     valid_frames,
  output logic [psfr_pkg::CNT_W-1:0]     zero_frames_held,
  output logic [psfr_pkg::POS_W-1:0]     frames_written,
  output logic [psfr_pkg::POS_W-1:0]     frames_zero_filled
);
  import psfr_pkg::*;

  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int IDX1_W    = SLOT_W + 1;
  localparam int STORE_W   = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W;
  localparam int CMP_W     = ((SLOT_W > COUNT_W) ? SLOT_W : COUNT_W) + 1;
  localparam int RESET_CAP = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;

  // Ring state.
  logic [IDX1_W-1:0] capacity;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] head_next;
  logic [POS_W-1:0]  head_pos;
  logic [POS_W-1:0]  tail_pos;
  logic [POS_W-1:0]  written_total;
  logic [POS_W-1:0]  zero_total;
  logic [SLOT_W-1:0] zero_held;

  // Item and work registers.
  logic               it_func;
  logic [POS_W-1:0]   it_pos;
  logic [STORE_W-1:0] it_frame;
  logic [COUNT_W-1:0] it_count;
  logic [POS_W-1:0]   diff;
  logic               diff_flag;
  logic               empty_r;
  logic [SLOT_W-1:0]  held_r;
  logic [IDX1_W-1:0]  fill_left;
  logic [POS_W-1:0]   rest;
  logic               rd_err;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] rd_left;
  logic               iss_vld;
  logic               iss_last;

  // Memory port signals.
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_raddr;
  logic [STORE_W:0]     ram_wdata;
  logic [STORE_W:0]     ram_rdata;
  logic                 byp_hit;
  logic                 byp_val;
  logic                 mark_now;

  // Derived values.
  logic [SLOT_W-1:0]  held;
  logic [SLOT_W-1:0]  tail_step;
  logic [SLOT_W-1:0]  head_step;
  logic               full_after;
  logic [IDX1_W-1:0]  cfg_cap;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx,
                                                  input logic [IDX1_W-1:0] cap);
    logic [IDX1_W-1:0] n;
    n = IDX1_W'(idx) + IDX1_W'(1);
    return (n >= cap) ? '0 : n[SLOT_W-1:0];
  endfunction

  // Frames held between head and tail.
  always_comb begin
    if (head == tail) begin
      held = '0;
    end else if (head < tail) begin
      held = tail - head;
    end else begin
      held = SLOT_W'(capacity - IDX1_W'(head) + IDX1_W'(tail));
    end
  end

  // One push step: the ring overflows when the new tail meets the head.
  assign tail_step  = next_slot(tail, capacity);
  assign head_step  = next_slot(head, capacity);
  assign full_after = (tail_step == head);

  // Mark of the current head slot, bypassing a write made in the previous cycle.
  assign mark_now = byp_hit ? byp_val : ram_rdata[STORE_W];

  // Head index after this cycle; the memory keeps reading it between read items.
  always_comb begin
    head_next = head;
    if (cfg_we) begin
      head_next = '0;
    end else if (cmd.push && full_after) begin
      head_next = head_step;
    end
  end

  assign ram_we    = cmd.push;
  assign ram_wdata = cmd.push_zero ? {1'b1, {STORE_W{1'b0}}} : {1'b0, it_frame};
  assign ram_raddr = cmd.issue ? slot : head_next;

  psfr_ram #(
    .WIDTH (STORE_W + 1),
    .DEPTH (MAX_SLOTS)
  ) u_frames (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Bypass register for a read of the slot written in the same cycle.
  always_ff @(posedge clk) begin
    byp_hit <= ram_we && (tail == ram_raddr);
    byp_val <= cmd.push_zero;
  end

  // Capacity written through the configuration port, clamped to the legal range.
  always_comb begin
    logic [31:0] v;
    v = 32'(cfg_data);
    if (v < 32'd2) begin
      v = 32'd2;
    end else if (v > 32'(MAX_SLOTS)) begin
      v = 32'(MAX_SLOTS);
    end
    cfg_cap = IDX1_W'(v);
  end

  // Ring indices, positions, totals and capacity.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= IDX1_W'(RESET_CAP);
      head          <= '0;
      tail          <= '0;
      head_pos      <= '0;
      tail_pos      <= '0;
      written_total <= '0;
      zero_total    <= '0;
      zero_held     <= '0;
    end else if (cfg_we) begin
      // A new capacity empties the ring; the totals keep counting.
      capacity  <= cfg_cap;
      head      <= '0;
      tail      <= '0;
      head_pos  <= '0;
      tail_pos  <= '0;
      zero_held <= '0;
    end else begin
      head <= head_next;
      if (cmd.clamp && empty_r) begin
        head_pos <= it_pos;
        tail_pos <= it_pos;
      end
      if (cmd.push) begin
        tail          <= tail_step;
        tail_pos      <= tail_pos + POS_W'(1);
        written_total <= written_total + POS_W'(1);
        zero_total    <= zero_total + POS_W'(cmd.push_zero);
        zero_held     <= zero_held + SLOT_W'(cmd.push_zero)
                         - SLOT_W'(full_after && mark_now);
        if (full_after) begin
          head_pos <= head_pos + POS_W'(1);
        end
      end
      if (cmd.finish) begin
        tail_pos      <= tail_pos + rest;
        head_pos      <= head_pos + rest;
        written_total <= written_total + rest;
        zero_total    <= zero_total + rest;
      end
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_func  <= func;
      it_pos   <= position;
      it_frame <= frame_in[STORE_W-1:0];
      it_count <= count;
    end
  end

  // Position difference against the tail for writes, the head for reads.
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      empty_r <= (head == tail);
      held_r  <= held;
      if (it_func == FUNC_READ) begin
        diff      <= it_pos - head_pos;
        diff_flag <= (it_pos < head_pos);
      end else begin
        diff      <= it_pos - tail_pos;
        diff_flag <= (it_pos > tail_pos);
      end
    end
  end

  // Gap clamp: at most one ring's worth of zero slots, the rest skips ahead.
  always_ff @(posedge clk) begin
    logic gap_ge;
    gap_ge = (diff[POS_W-1:IDX1_W] != '0) || (diff[IDX1_W-1:0] >= capacity);
    if (cmd.clamp) begin
      if (!empty_r && diff_flag) begin
        fill_left <= gap_ge ? capacity : diff[IDX1_W-1:0];
        rest      <= gap_ge ? (diff - POS_W'(capacity)) : '0;
      end else begin
        fill_left <= '0;
        rest      <= '0;
      end
    end else if (cmd.push && cmd.push_zero) begin
      fill_left <= fill_left - IDX1_W'(1);
    end
  end

  // Read range check and first slot; then one slot per issue.
  always_ff @(posedge clk) begin
    logic [SLOT_W-1:0] off_lo;
    logic              off_fits;
    logic              cnt_ok;
    logic              cnt_fits;
    logic [CMP_W-1:0]  room;
    logic [IDX1_W-1:0] sum;
    off_lo   = diff[SLOT_W-1:0];
    off_fits = (diff[POS_W-1:SLOT_W] == '0) && (off_lo <= held_r);
    cnt_ok   = (it_count != '0) && (CMP_W'(it_count) <= CMP_W'(MAX_READ));
    room     = CMP_W'(held_r) - CMP_W'(off_lo);
    cnt_fits = (CMP_W'(it_count) <= room);
    sum      = IDX1_W'(head) + IDX1_W'(off_lo);
    if (cmd.check) begin
      rd_err  <= (held_r == '0) || !cnt_ok || diff_flag || !off_fits || !cnt_fits;
      slot    <= (sum >= capacity) ? SLOT_W'(sum - capacity) : sum[SLOT_W-1:0];
      rd_left <= it_count;
    end else if (cmd.issue) begin
      slot    <= next_slot(slot, capacity);
      rd_left <= rd_left - COUNT_W'(1);
    end
  end

  // Read data returns in the cycle after its slot is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_vld <= 1'b0;
    end else begin
      iss_vld <= cmd.issue;
    end
    iss_last <= (rd_left == COUNT_W'(1));
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit_write || cmd.emit_err || iss_vld;
    end
    if (cmd.emit_write || cmd.emit_err || iss_vld) begin
      valid_frames       <= CNT_W'(held);
      zero_frames_held   <= CNT_W'(zero_held);
      frames_written     <= written_total;
      frames_zero_filled <= zero_total;
      if (iss_vld) begin
        frame_out <= FRAME_W'(ram_rdata[STORE_W-1:0]);
        last      <= iss_last;
        status    <= 1'b0;
      end else begin
        frame_out <= '0;
        last      <= 1'b1;
        status    <= cmd.emit_err;
      end
    end
  end

  // Status to the controller.
  assign sts.read_op   = (it_func == FUNC_READ);
  assign sts.fill_zero = (fill_left == '0);
  assign sts.fill_one  = (fill_left == IDX1_W'(1));
  assign sts.rd_err    = rd_err;
  assign sts.rd_last   = (rd_left == COUNT_W'(1));

endmodule

>>> design/position_synced_frame_ring_top.sv
// Top level of the position synced frame ring: controller plus datapath.
// Depends on psfr_pkg, psfr_ctrl, psfr_dp and (through the datapath) psfr_ram.
//
// Usage:
// - Items enter on start/busy: an item is taken at a rising edge with start high
//   and busy low. func selects a write of frame_in at position, or a read of
//   count frames beginning at position.
// - Results leave on result_strobe, one cycle each; the receiver cannot stall
//   and must take every strobed transaction.
// - A write gives one result after the states CALC, W_CLAMP, W_FILL, W_PUSH,
//   W_END and W_RESULT; W_FILL fills N zero slots (N is at most capacity), since
//   the gap fill pushes one frame per cycle through the single write port of the
//   frame memory. busy drops as the result is presented.
// - A read gives count results on consecutive cycles, the first after the states
//   CALC, R_CHECK and R_ISSUE, or one error result from R_ISSUE; busy drops with
//   the last slot read, so the next item can then follow.
// - The capacity register is written on cfg_valid/cfg_ready while the block is
//   idle; a write empties the ring and keeps the running totals.
// - Synchronous reset empties the ring, clears the totals and sets the capacity
//   to 1024 slots (or MAX_SLOTS if smaller). The frame memory needs no clearing.
module position_synced_frame_ring_top #(
  parameter int MAX_SLOTS  = 1024,
  parameter int FRAME_BITS = 32,
  parameter int MAX_READ   = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic [psfr_pkg::POS_W-1:0]     position,
  input  logic [psfr_pkg::FRAME_W-1:0]   frame_in,
  input  logic [psfr_pkg::COUNT_W-1:0]   count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psfr_pkg::CFG_W-1:0]     cfg_data,
  output logic                           result_strobe,
  output logic [psfr_pkg::FRAME_W-1:0]   frame_out,
  output logic                           last,
  output logic                           status,
  output logic [psfr_pkg::CNT_W-1:0]     valid_frames,
  output logic [psfr_pkg::CNT_W-1:0]     zero_frames_held,
  output logic [psfr_pkg::POS_W-1:0]     frames_written,
  output logic [psfr_pkg::POS_W-1:0]     frames_zero_filled
);
  import psfr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // The capacity register takes a transaction whenever no item is in work.
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  psfr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  psfr_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .FRAME_BITS (FRAME_BITS),
    .MAX_READ   (MAX_READ)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .func               (func),
    .position           (position),
    .frame_in           (frame_in),
    .count              (count),
    .result_strobe      (result_strobe),
    .frame_out          (frame_out),
    .last               (last),
    .status             (status),
    .valid_frames       (valid_frames),
    .zero_frames_held   (zero_frames_held),
    .frames_written     (frames_written),
    .frames_zero_filled (frames_zero_filled)
  );

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // An error result is always the final result of its item.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && status) |-> last)
    else $error("error result without last");

  // Results only follow work: each result strobe is preceded by a busy block.
  a_strobe_work: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> ($past(busy) || $past(busy, 2)))
    else $error("result strobe without preceding work");

  // Zero-filled frames held never exceed the frames held (checked for MAX_SLOTS up to 1024).
  a_zero_held: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> ((MAX_SLOTS > 1024) || (zero_frames_held <= valid_frames)))
    else $error("zero-filled count exceeds held frames");

endmodule
